>>> rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// shared constants and types of the reply frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

    localparam int unsigned MAX_FRAME = 64;
    localparam int unsigned WIN_DEPTH = 64;
    localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
    localparam int unsigned FILL_W    = WIN_AW + 1;
    localparam int unsigned SIZE_W    = 9;
    localparam int unsigned IDX_W     = FILL_W;

    localparam logic [7:0]        START_BYTE = 8'h55;
    localparam logic [7:0]        TRAIL_0    = 8'hEB;
    localparam logic [7:0]        TRAIL_1    = 8'hAA;
    localparam logic [SIZE_W-1:0] MIN_FRAME  = SIZE_W'(6);
    localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(MAX_FRAME);
    localparam logic [SIZE_W-1:0] HDR_TRL    = SIZE_W'(4);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ISSUE = 9'b000000010,
        ST_START = 9'b000000100,
        ST_LEN   = 9'b000001000,
        ST_TR0   = 9'b000010000,
        ST_TR1   = 9'b000100000,
        ST_SUM   = 9'b001000000,
        ST_ERD   = 9'b010000000,
        ST_ELD   = 9'b100000000
    } t_state;

    typedef struct packed {
        logic              we;
        logic [WIN_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [WIN_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic       load;
        logic [7:0] data;
        logic       last;
    } t_emit;

endpackage

`default_nettype wire

>>> rtl/core/rfd_if.sv
// ----------------------------------------------------------------------------
// rfd_if
// valid/ready channels for received bytes and frame bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface rfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/rfd_ram.sv
// ----------------------------------------------------------------------------
// rfd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/rfd_ctrl.sv
// ----------------------------------------------------------------------------
// rfd_ctrl
// window bookkeeping and scan sequencer over the window ram read port
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_ctrl
    import rfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rdata,
    output t_mem_req        o_mem,
    input  wire logic       i_emit_free,
    output t_emit           o_emit
);

    t_state              r_state, n_state;
    logic [WIN_AW-1:0]   r_head, n_head;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [7:0]          r_sum, n_sum;
    logic [WIN_AW-1:0]   w_off;
    logic [SIZE_W-1:0]   w_len_size;
    logic [SIZE_W-1:0]   w_fill_ext;
    logic [SIZE_W-1:0]   w_idx_ext;
    logic                w_accept;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_len_size = SIZE_W'(i_rdata) + HDR_TRL;
    assign w_fill_ext = SIZE_W'(r_fill);
    assign w_idx_ext  = SIZE_W'(r_idx);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_size      = r_size;
        n_idx       = r_idx;
        n_sum       = r_sum;
        w_off       = '0;
        o_mem.re    = 1'b0;
        o_emit.load = 1'b0;
        o_emit.data = i_rdata;
        o_emit.last = (w_idx_ext == r_size - SIZE_W'(1));

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_fill == FILL_W'(WIN_DEPTH)) begin
                        n_head = r_head + WIN_AW'(1);
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (r_fill == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    o_mem.re = 1'b1;
                    n_state  = ST_START;
                end
            end
            ST_START: begin
                if (i_rdata != START_BYTE) begin
                    n_head  = r_head + WIN_AW'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = ST_ISSUE;
                end else if (r_fill < FILL_W'(2)) begin
                    n_state = ST_IDLE;
                end else begin
                    w_off    = WIN_AW'(1);
                    o_mem.re = 1'b1;
                    n_state  = ST_LEN;
                end
            end
            ST_LEN: begin
                n_size = w_len_size;
                if (w_len_size < MIN_FRAME || w_len_size > MAX_SIZE) begin
                    n_head  = r_head + WIN_AW'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = ST_ISSUE;
                end else if (w_fill_ext < w_len_size) begin
                    n_state = ST_IDLE;
                end else begin
                    w_off    = WIN_AW'(w_len_size - SIZE_W'(2));
                    o_mem.re = 1'b1;
                    n_state  = ST_TR0;
                end
            end
            ST_TR0: begin
                if (i_rdata != TRAIL_0) begin
                    n_head  = r_head + WIN_AW'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = ST_ISSUE;
                end else begin
                    w_off    = WIN_AW'(r_size - SIZE_W'(1));
                    o_mem.re = 1'b1;
                    n_state  = ST_TR1;
                end
            end
            ST_TR1: begin
                if (i_rdata != TRAIL_1) begin
                    n_head  = r_head + WIN_AW'(1);
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = ST_ISSUE;
                end else begin
                    n_sum    = '0;
                    n_idx    = IDX_W'(2);
                    w_off    = WIN_AW'(2);
                    o_mem.re = 1'b1;
                    n_state  = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_idx_ext == r_size - SIZE_W'(3)) begin
                    if (r_sum != i_rdata) begin
                        n_head  = r_head + WIN_AW'(1);
                        n_fill  = r_fill - FILL_W'(1);
                        n_state = ST_ISSUE;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_ERD;
                    end
                end else begin
                    n_sum    = r_sum + i_rdata;
                    n_idx    = r_idx + IDX_W'(1);
                    w_off    = WIN_AW'(r_idx + IDX_W'(1));
                    o_mem.re = 1'b1;
                end
            end
            ST_ERD: begin
                if (i_emit_free) begin
                    w_off    = WIN_AW'(r_idx);
                    o_mem.re = 1'b1;
                    n_state  = ST_ELD;
                end
            end
            ST_ELD: begin
                o_emit.load = 1'b1;
                if (o_emit.last) begin
                    n_head  = r_head + WIN_AW'(r_size);
                    n_fill  = r_fill - FILL_W'(r_size);
                    n_state = ST_ISSUE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = ST_ERD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_mem.raddr = r_head + w_off;
        o_mem.we    = w_accept;
        o_mem.waddr = r_head + r_fill[WIN_AW-1:0];
        o_mem.wdata = i_rx_byte;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_idx  <= n_idx;
        r_sum  <= n_sum;
    end

endmodule

`default_nettype wire

>>> rtl/core/reply_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// reply_frame_deframer_top
// finds and forwards checksummed, length prefixed reply frames in a byte stream
// ----------------------------------------------------------------------------
// Each received byte is appended to a 64-byte window held in a single-port-read
// RAM, after which a sequencer rescans the window from its oldest byte and the
// receive channel stays not ready until the scan has finished. A frame is 0x55,
// a length L, L body bytes whose last is the 8-bit sum of the others, then
// 0xEB 0xAA; a valid frame is sent out byte by byte with frame_last on its
// final byte, and a failing candidate costs one dropped byte. The scan is paced
// by the one window read port: it checks the start byte, reads the length, checks
// both trailer bytes, sums the body for the checksum, then reads each frame byte
// for the output register, waiting while the output is stalled. The window needs
// no clearing after reset; it is usable from the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_frame_deframer_top
    import rfd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rfd_rx_if.sink      i_rx,
    rfd_frame_if.source o_frame
);

    t_mem_req   w_mem;
    t_emit      w_emit;
    logic [7:0] w_rdata;
    logic       w_free;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    assign w_free = !r_out_valid || o_frame.ready;

    rfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .i_rx_byte   (i_rx.rx_byte),
        .o_in_ready  (i_rx.ready),
        .i_rdata     (w_rdata),
        .o_mem       (w_mem),
        .i_emit_free (w_free),
        .o_emit      (w_emit)
    );

    rfd_ram #(
        .WIDTH (8),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.load) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.load) begin
            r_out_byte <= w_emit.data;
            r_out_last <= w_emit.last;
        end
    end

    assign o_frame.valid      = r_out_valid;
    assign o_frame.frame_byte = r_out_byte;
    assign o_frame.frame_last = r_out_last;

endmodule

`default_nettype wire

>>> rtl/core/rfd_checker.sv
// ----------------------------------------------------------------------------
// rfd_checker
// port level checks of the reply frame deframer, bound to its top level
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_checker
    import rfd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    // stalled output holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output changed while stalled");

    // every received transfer starts a rescan
    a_busy_after_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready right after a receive transfer");

    // a frame always ends on the second trailer byte
    a_last_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_byte == TRAIL_1)
        else $error("frame end not on trailer byte");

    // a byte that follows a frame end opens a new frame
    a_first_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last ##1 i_out_valid |->
            i_out_byte == START_BYTE)
        else $error("frame does not open with the start byte");

endmodule

bind reply_frame_deframer_top rfd_checker u_rfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rx.valid),
    .i_in_ready  (i_rx.ready),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_byte  (o_frame.frame_byte),
    .i_out_last  (o_frame.frame_last)
);

`default_nettype wire
